[sv/mu8dh_pkg.sv]
`timescale 1ns / 1ps

package mu8dh_pkg;

	// Default width of the saturating character counter.
	localparam int unsigned COUNT_BITS_DEFAULT = 16;

	// Hash multiplier; applied as (h << 5) + (h << 2) + h.
	localparam logic [31:0] HASH_MULT = 32'd37;

	// Bit masks used on lead and continuation bytes.
	localparam logic [7:0] LEAD_MASK  = 8'h80;
	localparam logic [7:0] THREE_MASK = 8'h20;
	localparam logic [7:0] CONT_BITS  = 8'h3f;
	localparam logic [7:0] TWO_BITS   = 8'h1f;
	localparam logic [7:0] THREE_BITS = 8'h0f;

	// Continuation bytes still expected in the current sequence.
	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_ONE  = 2'd1,
		PEND_TWO  = 2'd2
	} pend_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic        char_ready;
		logic [15:0] char_code;
		logic        string_end;
		logic signed [31:0] string_hash;
		logic [15:0] char_total;
		logic        cut_short;
	} out_beat_t;

	// Decoder state that is not parameter dependent.
	typedef struct packed {
		pend_t       pending;
		logic [15:0] partial;
		logic [31:0] hash;
	} dec_state_t;

endpackage

[sv/mu8dh_stream_if.sv]
`timescale 1ns / 1ps

interface mu8dh_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/mu8dh_decode.sv]
`timescale 1ns / 1ps

module mu8dh_decode #(
	parameter int unsigned COUNT_BITS = mu8dh_pkg::COUNT_BITS_DEFAULT
) (
	input  logic [7:0]              data_byte,
	input  mu8dh_pkg::dec_state_t   state,
	input  logic [COUNT_BITS-1:0]   count,
	output mu8dh_pkg::dec_state_t   state_next,
	output logic [COUNT_BITS-1:0]   count_next,
	output logic                    produce,
	output mu8dh_pkg::out_beat_t    result
);
	import mu8dh_pkg::*;

	logic        finish;
	logic [15:0] chr;
	logic [31:0] chr_ext;
	logic [31:0] hash_fin;
	logic [COUNT_BITS-1:0] count_fin;

	// Hash update of a finished character: hash * 37 + sign-extended char.
	assign chr_ext  = {{16{chr[15]}}, chr};
	assign hash_fin = (state.hash << 5) + (state.hash << 2) + state.hash + chr_ext;
	assign count_fin = (&count) ? count : count + 1'b1;

	always_comb begin
		state_next = state;
		finish     = 1'b0;
		chr        = 16'd0;
		case (state.pending)
			PEND_TWO: begin
				state_next.partial = state.partial + {4'd0, 6'(data_byte & CONT_BITS), 6'd0};
				state_next.pending = PEND_ONE;
			end
			PEND_ONE: begin
				chr    = state.partial + {10'd0, 6'(data_byte & CONT_BITS)};
				finish = 1'b1;
			end
			default: begin
				state_next.pending = PEND_NONE;
				if ((data_byte & LEAD_MASK) != 8'd0) begin
					if ((data_byte & THREE_MASK) != 8'd0) begin
						state_next.partial = {4'(data_byte & THREE_BITS), 12'd0};
						state_next.pending = PEND_TWO;
					end else begin
						state_next.partial = {5'd0, 5'(data_byte & TWO_BITS), 6'd0};
						state_next.pending = PEND_ONE;
					end
				end else begin
					chr    = {8'd0, data_byte};
					finish = 1'b1;
				end
			end
		endcase
		if (finish) begin
			state_next.pending = PEND_NONE;
			state_next.partial = 16'd0;
			state_next.hash    = hash_fin;
		end
		// The terminator clears the whole string state.
		if (data_byte == 8'd0) begin
			state_next = '{pending: PEND_NONE, partial: 16'd0, hash: 32'd0};
		end
	end

	always_comb begin
		count_next        = finish ? count_fin : count;
		produce           = finish;
		result.char_ready = 1'b1;
		result.char_code  = chr;
		result.string_end = 1'b0;
		result.string_hash = hash_fin;
		result.char_total = 16'(count_fin);
		result.cut_short  = 1'b0;
		// The terminator overrides everything, also in place of a continuation byte.
		if (data_byte == 8'd0) begin
			count_next         = '0;
			produce            = 1'b1;
			result.char_ready  = 1'b0;
			result.char_code   = 16'd0;
			result.string_end  = 1'b1;
			result.string_hash = state.hash;
			result.char_total  = 16'(count);
			result.cut_short   = (state.pending != PEND_NONE);
		end
	end

endmodule

[sv/modified_utf8_decode_hash.sv]
`timescale 1ns / 1ps

// Channel    Role     Payload                      Beat
// byte_ch    sink     data_byte                    one string byte
// result_ch  source   char_ready .. cut_short      one decoded character or string end
//
// An accepted byte is registered in the input stage and decoded in the next
// cycle; its result is then registered in the result register, which presents it
// on result_ch. Throughput is one byte per cycle while no held result stalls
// the input stage; the only loop is the decoder state update.
// arst_n clears the valid bits and the decoder state (pending, partial, hash, count).
// A full result register that is not taken stalls only bytes that produce a
// result; lead and middle bytes keep flowing into the decoder state.

module modified_utf8_decode_hash #(
	parameter int unsigned COUNT_BITS = mu8dh_pkg::COUNT_BITS_DEFAULT
) (
	input logic                clk,
	input logic                arst_n,
	mu8dh_stream_if.sink       byte_ch,
	mu8dh_stream_if.source     result_ch
);
	import mu8dh_pkg::*;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Decoder state.
	dec_state_t            state_q;
	logic [COUNT_BITS-1:0] count_q;

	// Result register.
	logic      out_valid_q;
	out_beat_t out_q;

	dec_state_t            state_next;
	logic [COUNT_BITS-1:0] count_next;
	logic                  produce;
	out_beat_t             result;
	logic                  out_free;
	logic                  advance;

	mu8dh_decode #(
		.COUNT_BITS(COUNT_BITS)
	) u_decode (
		.data_byte (byte_s1),
		.state     (state_q),
		.count     (count_q),
		.state_next(state_next),
		.count_next(count_next),
		.produce   (produce),
		.result    (result)
	);

	// The result slot is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || result_ch.ready;
	// The staged byte moves on unless it needs the result slot and that slot is held.
	assign advance  = valid_s1 && (!produce || out_free);

	assign byte_ch.ready     = !valid_s1 || advance;
	assign result_ch.valid   = out_valid_q;
	assign result_ch.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.payload.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{pending: PEND_NONE, partial: 16'd0, hash: 32'd0};
			count_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_q <= result;
		end
	end

endmodule
